### rtl/mvlt_pkg.sv
package mvlt_pkg;

	localparam int KEY_W           = 60;
	localparam int HASH_W          = 64;
	localparam int MAC_W           = 48;
	localparam int VLAN_W          = 12;
	localparam int MASK_W          = 10;
	localparam int DEF_TABLE_DEPTH = 1024;

	localparam logic [MASK_W-1:0] MASK_RESET = MASK_W'(1023);

	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [HASH_W-1:0] hash_t;

	typedef enum logic [1:0] {
		FUNC_LOOKUP = 2'd0,
		FUNC_LEARN  = 2'd1,
		FUNC_DELETE = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

endpackage

### rtl/mac_vlan_endpoint_learning_table.sv
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   func mac vlan time_value endpoint_addr endpoint_port
// rsp       out        rsp_valid/rsp_stall   found peer_addr peer_port
// cfg       in         index_mask_we         index_mask_wdata
//
// One request at a time. Lookup: the shared-multiplier hash, one table read,
// compare, then output load. Learn: hash, table write, output load. Delete:
// eff_mask+1 table reads, the scan end state, then output load. Multicast lookup
// or learn and unused func go straight to output load.
// After reset the table is swept to zero while req is stalled.
// The result sits in an output register; a stalled rsp holds the block before
// it returns to idle.
module mac_vlan_endpoint_learning_table
	import mvlt_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                index_mask_we,
	input  logic [MASK_W-1:0]   index_mask_wdata,

	input  logic                req_valid,
	output logic                req_stall,
	input  logic [1:0]          func,
	input  logic [MAC_W-1:0]    mac,
	input  logic [VLAN_W-1:0]   vlan,
	input  logic [31:0]         time_value,
	input  logic [31:0]         endpoint_addr,
	input  logic [15:0]         endpoint_port,

	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic                found,
	output logic [31:0]         peer_addr,
	output logic [15:0]         peer_port
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_CMP,
		ST_SCAN,
		ST_SCAN_END,
		ST_DONE
	} state_t;

	typedef struct packed {
		key_t        key;
		logic [31:0] addr;
		logic [15:0] port;
	} meta_t;

	state_t             state_q;
	logic [MASK_W-1:0]  index_mask_q;
	logic [IDX_W-1:0]   clr_idx_q;
	logic [IDX_W-1:0]   scan_idx_q;
	logic               scan_vld_s1;
	logic [IDX_W-1:0]   scan_addr_s1;

	func_t              func_q;
	key_t               key_q;
	logic [31:0]        tv_q;
	logic [31:0]        ea_q;
	logic [15:0]        ep_q;

	logic               res_found_q;
	logic [31:0]        res_addr_q;
	logic [15:0]        res_port_q;
	logic               rsp_valid_q;
	logic               found_q;
	logic [31:0]        peer_addr_q;
	logic [15:0]        peer_port_q;

	meta_t              meta_mem [TABLE_DEPTH];
	logic [31:0]        time_mem [TABLE_DEPTH];
	meta_t              meta_rd_q;
	logic [31:0]        time_rd_q;

	logic               req_xfer;
	logic               rsp_free;
	logic [IDX_W-1:0]   eff_mask;
	key_t               req_key;
	logic               hash_start;
	logic               hash_done;
	hash_t              hash_val;
	logic [IDX_W-1:0]   slot;
	logic               scan_match;
	logic               lookup_hit;

	logic               meta_we;
	logic               time_we;
	logic [IDX_W-1:0]   wr_addr;
	meta_t              meta_wd;
	logic [31:0]        time_wd;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;

	assign req_stall = (state_q != ST_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign eff_mask  = IDX_W'(32'(index_mask_q) & 32'(TABLE_DEPTH - 1));
	assign req_key   = {vlan, mac};

	assign hash_start = req_xfer && !mac[0]
		&& (func == FUNC_LOOKUP || func == FUNC_LEARN);

	mvlt_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (req_key),
		.done   (hash_done),
		.hash   (hash_val)
	);

	assign slot       = hash_val[IDX_W-1:0] & eff_mask;
	assign scan_match = scan_vld_s1 && meta_rd_q.addr == ea_q && meta_rd_q.port == ep_q;
	assign lookup_hit = meta_rd_q.key == key_q && time_rd_q >= tv_q;

	// table port control
	always_comb begin
		meta_we = 1'b0;
		time_we = 1'b0;
		wr_addr = scan_addr_s1;
		meta_wd = '0;
		time_wd = '0;
		rd_en   = 1'b0;
		rd_addr = scan_idx_q;
		priority if (state_q == ST_CLEAR) begin
			meta_we = 1'b1;
			time_we = 1'b1;
			wr_addr = clr_idx_q;
		end else if (state_q == ST_HASH && hash_done) begin
			if (func_q == FUNC_LEARN) begin
				meta_we = 1'b1;
				time_we = 1'b1;
				wr_addr = slot;
				meta_wd = '{key: key_q, addr: ea_q, port: ep_q};
				time_wd = tv_q;
			end else begin
				rd_en   = 1'b1;
				rd_addr = slot;
			end
		end else begin
			// delete: drop the age of a matching slot, one stage behind the read
			time_we = scan_match;
			rd_en   = (state_q == ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[wr_addr] <= meta_wd;
		end
		if (time_we) begin
			time_mem[wr_addr] <= time_wd;
		end
		if (rd_en) begin
			meta_rd_q <= meta_mem[rd_addr];
			time_rd_q <= time_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_mask_q <= MASK_RESET;
		end else if (index_mask_we) begin
			index_mask_q <= index_mask_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_idx_q    <= '0;
			scan_idx_q   <= '0;
			scan_vld_s1  <= 1'b0;
			scan_addr_s1 <= '0;
			func_q       <= FUNC_NONE;
			key_q        <= '0;
			tv_q         <= '0;
			ea_q         <= '0;
			ep_q         <= '0;
			res_found_q  <= 1'b0;
			res_addr_q   <= '0;
			res_port_q   <= '0;
			rsp_valid_q  <= 1'b0;
			found_q      <= 1'b0;
			peer_addr_q  <= '0;
			peer_port_q  <= '0;
		end else begin
			scan_vld_s1  <= (state_q == ST_SCAN);
			scan_addr_s1 <= scan_idx_q;
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == IDX_W'(TABLE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_xfer) begin
						func_q      <= func_t'(func);
						key_q       <= req_key;
						tv_q        <= time_value;
						ea_q        <= endpoint_addr;
						ep_q        <= endpoint_port;
						res_found_q <= 1'b0;
						res_addr_q  <= '0;
						res_port_q  <= '0;
						scan_idx_q  <= '0;
						priority if (hash_start) begin
							state_q <= ST_HASH;
						end else if (func == FUNC_DELETE) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_HASH: begin
					if (hash_done) begin
						state_q <= (func_q == FUNC_LOOKUP) ? ST_CMP : ST_DONE;
					end
				end
				ST_CMP: begin
					if (lookup_hit) begin
						res_found_q <= 1'b1;
						res_addr_q  <= meta_rd_q.addr;
						res_port_q  <= meta_rd_q.port;
					end
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (scan_idx_q == eff_mask) begin
						state_q <= ST_SCAN_END;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				ST_SCAN_END: state_q <= ST_DONE;
				ST_DONE: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						found_q     <= res_found_q;
						peer_addr_q <= res_addr_q;
						peer_port_q <= res_port_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign found     = found_q;
	assign peer_addr = peer_addr_q;
	assign peer_port = peer_port_q;

endmodule

### rtl/mvlt_hash.sv
// 64-bit murmur3 finalizer on one shared 32x32 multiplier.
// Each 64x64 (low half) product takes three partial products plus one
// accumulate step; the finalizer runs two such rounds, one per mix constant.
module mvlt_hash
	import mvlt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  key_t  key,
	output logic  done,
	output hash_t hash
);

	localparam hash_t MIX_C1    = 64'hff51afd7ed558ccd;
	localparam hash_t MIX_C2    = 64'hc4ceb9fe1a85ec53;
	localparam int    MIX_SHIFT = 33;

	typedef enum logic {
		H_IDLE,
		H_MUL
	} hstate_t;

	hstate_t     state_q;
	logic [1:0]  cnt_q;
	logic        rnd_q;
	logic        done_q;
	hash_t       k_q;
	hash_t       acc_q;
	hash_t       prod_q;

	hash_t       key_ext;
	hash_t       mix_c;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	hash_t       fin;

	assign key_ext = HASH_W'(key);
	assign mix_c   = rnd_q ? MIX_C2 : MIX_C1;
	// partial products: lo*lo, lo*hi, hi*lo
	assign mul_a   = (cnt_q == 2'd2) ? k_q[63:32] : k_q[31:0];
	assign mul_b   = (cnt_q == 2'd1) ? mix_c[63:32] : mix_c[31:0];
	assign fin     = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			cnt_q   <= '0;
			rnd_q   <= 1'b0;
			done_q  <= 1'b0;
			k_q     <= '0;
			acc_q   <= '0;
			prod_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				H_IDLE: begin
					if (start) begin
						k_q     <= key_ext ^ (key_ext >> MIX_SHIFT);
						cnt_q   <= '0;
						rnd_q   <= 1'b0;
						state_q <= H_MUL;
					end
				end
				H_MUL: begin
					prod_q <= HASH_W'(mul_a) * HASH_W'(mul_b);
					unique case (cnt_q)
						2'd0: cnt_q <= 2'd1;
						2'd1: begin
							acc_q <= prod_q;
							cnt_q <= 2'd2;
						end
						2'd2: begin
							acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
							cnt_q        <= 2'd3;
						end
						2'd3: begin
							k_q   <= fin ^ (fin >> MIX_SHIFT);
							cnt_q <= '0;
							if (rnd_q) begin
								done_q  <= 1'b1;
								state_q <= H_IDLE;
							end else begin
								rnd_q <= 1'b1;
							end
						end
						default: cnt_q <= '0;
					endcase
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign hash = k_q;

endmodule

### tb/tb.sv
module tb;
	import mvlt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH         = DEF_TABLE_DEPTH;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 400;
	localparam int KEY_POOL      = 12;
	localparam int PEER_POOL     = 6;

	typedef struct packed {
		func_t            op;
		logic [MAC_W-1:0] mac;
		logic [VLAN_W-1:0] vlan;
		logic [31:0]      tv;
		logic [31:0]      ea;
		logic [15:0]      ep;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [31:0] addr;
		logic [15:0] port;
	} rsp_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              index_mask_we = 1'b0;
	logic [MASK_W-1:0] index_mask_wdata = '0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	logic [1:0]        func = '0;
	logic [MAC_W-1:0]  mac = '0;
	logic [VLAN_W-1:0] vlan = '0;
	logic [31:0]       time_value = '0;
	logic [31:0]       endpoint_addr = '0;
	logic [15:0]       endpoint_port = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	logic              found;
	logic [31:0]       peer_addr;
	logic [15:0]       peer_port;

	// shadow copy of the forwarding table
	key_t              key_mem  [DEPTH];
	logic [31:0]       seen_mem [DEPTH];
	logic [31:0]       addr_mem [DEPTH];
	logic [15:0]       port_mem [DEPTH];
	logic [MASK_W-1:0] table_mask = MASK_RESET;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	req_t cur_req;

	int  reqs_queued = 0;
	int  reqs_accepted = 0;
	int  rsps_checked = 0;
	int  mismatches = 0;
	int  n_lookups = 0;
	int  n_hits = 0;
	int  n_learns = 0;
	int  n_deletes = 0;
	int  mask_writes = 0;
	int  send_gap = 0;
	int  recv_gap = 0;
	int  holds_asked = 0;
	int  holds_served = 0;
	int  hold_left = 0;
	bit  sender_idles = 1'b0;
	bit  receiver_idles = 1'b0;

	logic [MAC_W-1:0]  pool_mac  [KEY_POOL];
	logic [VLAN_W-1:0] pool_vlan [KEY_POOL];
	logic [31:0]       pool_addr [PEER_POOL];
	logic [15:0]       pool_port [PEER_POOL];
	logic [31:0]       clock_now;

	mac_vlan_endpoint_learning_table u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.index_mask_we    (index_mask_we),
		.index_mask_wdata (index_mask_wdata),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.func             (func),
		.mac              (mac),
		.vlan             (vlan),
		.time_value       (time_value),
		.endpoint_addr    (endpoint_addr),
		.endpoint_port    (endpoint_port),
		.rsp_valid        (rsp_valid),
		.rsp_stall        (rsp_stall),
		.found            (found),
		.peer_addr        (peer_addr),
		.peer_port        (peer_port)
	);

	always #2 clk = ~clk;

	// murmur3 64-bit finalizer, masked down to a slot
	function automatic logic [MASK_W-1:0] slot_of(key_t k, logic [MASK_W-1:0] m);
		logic [63:0] h;
		h = {4'b0, k};
		h = h ^ (h >> 33);
		h = h * 64'hff51afd7ed558ccd;
		h = h ^ (h >> 33);
		h = h * 64'hc4ceb9fe1a85ec53;
		h = h ^ (h >> 33);
		return h[MASK_W-1:0] & m;
	endfunction

	function automatic rsp_t table_predict(req_t r);
		rsp_t              res;
		key_t              k;
		logic [MASK_W-1:0] m;
		logic [MASK_W-1:0] s;
		int                i;
		res = '0;
		k = {r.vlan, r.mac};
		m = table_mask & MASK_W'(DEPTH - 1);
		s = slot_of(k, m);
		case (r.op)
		FUNC_LOOKUP: begin
			n_lookups++;
			if (!r.mac[0] && key_mem[s] == k && seen_mem[s] >= r.tv) begin
				res.found = 1'b1;
				res.addr = addr_mem[s];
				res.port = port_mem[s];
				n_hits++;
			end
		end
		FUNC_LEARN: begin
			n_learns++;
			if (!r.mac[0]) begin
				key_mem[s] = k;
				seen_mem[s] = r.tv;
				addr_mem[s] = r.ea;
				port_mem[s] = r.ep;
			end
		end
		FUNC_DELETE: begin
			n_deletes++;
			for (i = 0; i <= int'(m); i++)
				if (addr_mem[i] == r.ea && port_mem[i] == r.ep)
					seen_mem[i] = '0;
		end
		default: ;
		endcase
		return res;
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				expected_rsps.push_back(table_predict(cur_req));
				reqs_accepted++;
			end
			if (!req_valid || !req_stall) begin
				if (send_gap == 0 && sender_idles && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 18);
				if (send_gap > 0) begin
					send_gap--;
					req_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					cur_req = pending_reqs.pop_front();
					req_valid <= 1'b1;
					func <= cur_req.op;
					mac <= cur_req.mac;
					vlan <= cur_req.vlan;
					time_value <= cur_req.tv;
					endpoint_addr <= cur_req.ea;
					endpoint_port <= cur_req.ep;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_served != holds_asked) begin
			holds_served <= holds_served + 1;
			hold_left <= HOLD_CYCLES;
		end
	end

	// result monitor and receiver stall
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				rsps_checked++;
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected result: found %0b addr %h port %h", $time,
						found, peer_addr, peer_port);
					mismatches++;
				end else begin
					want = expected_rsps.pop_front();
					if (found !== want.found) begin
						$display("%0t: found mismatch: expected %0b, actual %0b", $time,
							want.found, found);
						mismatches++;
					end
					if (peer_addr !== want.addr) begin
						$display("%0t: peer_addr mismatch: expected %h, actual %h", $time,
							want.addr, peer_addr);
						mismatches++;
					end
					if (peer_port !== want.port) begin
						$display("%0t: peer_port mismatch: expected %h, actual %h", $time,
							want.port, peer_port);
						mismatches++;
					end
				end
			end
			if (hold_left != 0) begin
				rsp_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				rsp_stall <= 1'b1;
			end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
				recv_gap = $urandom_range(0, 17);
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	task automatic queue_req(input func_t op, input logic [MAC_W-1:0] m,
		input logic [VLAN_W-1:0] v, input logic [31:0] tv, input logic [31:0] ea,
		input logic [15:0] ep);
		req_t r;
		r.op = op;
		r.mac = m;
		r.vlan = v;
		r.tv = tv;
		r.ea = ea;
		r.ep = ep;
		pending_reqs.push_back(r);
		reqs_queued++;
	endtask

	// wait until every transfer has its result, then let the block go idle
	task automatic drain();
		while (reqs_accepted != reqs_queued || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mask(input logic [MASK_W-1:0] m);
		index_mask_we <= 1'b1;
		index_mask_wdata <= m;
		@(posedge clk);
		index_mask_we <= 1'b0;
		table_mask = m;
		mask_writes++;
	endtask

	task automatic refresh_pools();
		int i;
		for (i = 0; i < KEY_POOL; i++) begin
			pool_mac[i] = MAC_W'({$urandom, $urandom}) & ~MAC_W'(1);
			pool_vlan[i] = VLAN_W'($urandom);
		end
		for (i = 0; i < PEER_POOL; i++) begin
			pool_addr[i] = $urandom;
			pool_port[i] = 16'($urandom);
		end
	endtask

	// mostly learn/lookup traffic on a small set of stations, plus noise
	task automatic queue_random_req();
		int    pick;
		int    k;
		int    e;
		func_t op;
		logic [MAC_W-1:0]  m;
		logic [VLAN_W-1:0] v;
		logic [31:0]       tv;
		logic [31:0]       ea;
		logic [15:0]       ep;
		pick = $urandom_range(0, 99);
		k = $urandom_range(0, KEY_POOL - 1);
		e = $urandom_range(0, PEER_POOL - 1);
		m = pool_mac[k];
		v = pool_vlan[k];
		ea = pool_addr[e];
		ep = pool_port[e];
		tv = clock_now;
		op = FUNC_LEARN;
		if (pick < 40) begin
			op = FUNC_LEARN;
		end else if (pick < 80) begin
			op = FUNC_LOOKUP;
			tv = clock_now - $urandom_range(0, 24);
		end else if (pick < 85) begin
			op = FUNC_LOOKUP;
			m = MAC_W'({$urandom, $urandom});
			v = VLAN_W'($urandom);
			tv = $urandom_range(0, 1) ? 32'd0 : $urandom;
		end else if (pick < 90) begin
			op = FUNC_LEARN;
			m = MAC_W'({$urandom, $urandom});
			v = VLAN_W'($urandom);
			tv = $urandom;
			ea = $urandom;
			ep = 16'($urandom);
		end else if (pick < 94) begin
			op = FUNC_DELETE;
		end else if (pick < 97) begin
			op = FUNC_NONE;
			m = MAC_W'({$urandom, $urandom});
			tv = $urandom;
		end else begin
			op = $urandom_range(0, 1) ? FUNC_LOOKUP : FUNC_LEARN;
			m[0] = 1'b1;
		end
		queue_req(op, m, v, tv, ea, ep);
		clock_now = clock_now + $urandom_range(0, 3);
	endtask

	task automatic run_phase(input logic [MASK_W-1:0] m, input int n, input bit idles,
		input bit with_hold);
		drain();
		write_mask(m);
		refresh_pools();
		sender_idles = idles;
		receiver_idles = idles;
		if (with_hold)
			holds_asked++;
		repeat (n) queue_random_req();
	endtask

	initial begin
		foreach (key_mem[i]) begin
			key_mem[i] = '0;
			seen_mem[i] = '0;
			addr_mem[i] = '0;
			port_mem[i] = '0;
		end
		clock_now = $urandom;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// hold off until the post-reset table sweep is done
		while (req_stall !== 1'b0)
			@(posedge clk);
		write_mask(10'd1023);

		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		queue_req(FUNC_LOOKUP, '0, '0, '0, '0, '0);
		queue_req(FUNC_LOOKUP, 48'hFFFF_FFFF_FFFF, 12'hFFF, '0, '0, '0);
		queue_req(FUNC_LEARN, 48'hFFFF_FFFF_FFFE, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			16'hFFFF);
		queue_req(FUNC_LOOKUP, 48'hFFFF_FFFF_FFFE, 12'hFFF, 32'hFFFF_FFFF, '0, '0);
		queue_req(FUNC_LOOKUP, 48'hFFFF_FFFF_FFFE, 12'hFFE, '0, '0, '0);
		queue_req(FUNC_LEARN, 48'hFB00_005E_0001, 12'h001, 32'd50, 32'h0A00_0002, 16'd99);
		queue_req(FUNC_LOOKUP, 48'hFB00_005E_0001, 12'h001, '0, '0, '0);
		queue_req(FUNC_LEARN, 48'h0000_0000_0002, '0, 32'd100, 32'h0A00_0001, 16'd4789);
		queue_req(FUNC_LOOKUP, 48'h0000_0000_0002, '0, 32'd100, '0, '0);
		queue_req(FUNC_LOOKUP, 48'h0000_0000_0002, '0, 32'd101, '0, '0);
		queue_req(FUNC_LEARN, 48'hA5A5_5A5A_0F0E, 12'h800, 32'h8000_0000, 32'h0A00_0001,
			16'd4789);
		queue_req(FUNC_LOOKUP, 48'hA5A5_5A5A_0F0E, 12'h800, 32'h7FFF_FFFF, '0, '0);
		queue_req(FUNC_NONE, 48'hFFFF_FFFF_FFFE, 12'hFFF, '0, 32'hFFFF_FFFF, 16'hFFFF);
		// delete zeroes the age but keeps key and endpoint
		queue_req(FUNC_DELETE, '0, '0, '0, 32'h0A00_0001, 16'd4789);
		queue_req(FUNC_LOOKUP, 48'h0000_0000_0002, '0, 32'd0, '0, '0);
		queue_req(FUNC_LOOKUP, 48'h0000_0000_0002, '0, 32'd1, '0, '0);
		queue_req(FUNC_LEARN, 48'h0000_0000_0002, '0, 32'd5, '0, '0);
		queue_req(FUNC_DELETE, '0, '0, '0, '0, '0);
		queue_req(FUNC_LOOKUP, 48'h0000_0000_0002, '0, 32'd0, '0, '0);
		queue_req(FUNC_LOOKUP, 48'hFFFF_FFFF_FFFE, 12'hFFF, 32'd1, '0, '0);
		queue_req(FUNC_LEARN, '0, '0, 32'd7, 32'd1, 16'd1);
		queue_req(FUNC_LOOKUP, '0, '0, 32'd7, '0, '0);
		queue_req(FUNC_DELETE, '0, '0, '0, 32'hFFFF_FFFF, 16'hFFFF);
		queue_req(FUNC_LOOKUP, 48'hFFFF_FFFF_FFFE, 12'hFFF, 32'd1, '0, '0);

		run_phase(10'd0, 110, 1'b1, 1'b0);
		run_phase(10'd1023, 150, 1'b1, 1'b1);
		run_phase(10'd7, 130, 1'b0, 1'b0);
		run_phase(10'd1000, 130, 1'b1, 1'b0);
		run_phase(10'd63, 130, 1'b1, 1'b0);
		run_phase(10'd1, 120, 1'b1, 1'b0);
		// closing stretch at full rate
		run_phase(10'd1023, 160, 1'b0, 1'b0);
		drain();

		$display("Run covered %0d requests: %0d lookups (%0d hits), %0d learns, %0d deletes,",
			reqs_accepted, n_lookups, n_hits, n_learns, n_deletes);
		$display("under %0d mask writes; %0d results compared, %0d mismatches.",
			mask_writes, rsps_checked, mismatches);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#4ms;
		$display("Timeout: %0d of %0d requests transferred, %0d results outstanding",
			reqs_accepted, reqs_queued, expected_rsps.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
